>>> src/ols_pkg.sv
// shared types and codes for the ordered list with value search
`default_nettype none
package ols_pkg;

  // payload widths fixed by the item format
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  // operation codes, codes 6 and 7 do nothing
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_DELETE     = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_PEEK_FRONT = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage
`default_nettype wire

>>> src/ols_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module ols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/ordered_list_with_value_search_top.sv
// bounded ordered list of 32-bit values with push, pop, delete, search and peek
//
//  channel  | direction | tdata fields (lsb first)                          | extra
//  ---------+-----------+---------------------------------------------------+------
//  in_      | slave     | operation[2:0], operand_value[34:3], zero pad     | none
//  out_     | master    | status[1:0], result_value[33:2],                  | none
//           |           | entry_count[38:34], is_empty[39]                  |
//
// one item at a time; a list held in a circular buffer ram, one read port and
// one write port, walked by a small sequencer with one 32-bit equality compare
// push front / push back: ram write at accept, then result load
// pop / peek: ram read, then result load; ops on an empty list, full pushes,
// unused codes: result load only; search: ram read and compare per entry visited,
// then load; delete adds a ram read then write per entry that closes up the gap
// rst_n is synchronous; it clears the count and head, ram contents stay unknown
// a finished result waits in the output register; the next item is taken
// meanwhile, and only its own result load waits for out_tready
`default_nettype none
module ordered_list_with_value_search_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [ols_pkg::IN_W-1:0]   in_tdata,   // operation[2:0], operand_value[34:3]
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [ols_pkg::OUT_W-1:0]  out_tdata   // status, result_value, entry_count,
                                                      // is_empty
);
  import ols_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CAP_S  = (AW+1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CMP, S_SHRD, S_SHWR, S_DONE
  } state_t;

  // logical position to ram address, wrapping around the buffer end
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= CAP_S) begin
      s = s - CAP_S;
    end
    return s[AW-1:0];
  endfunction

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  // ram port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [VALUE_W-1:0]  ram_rdata;

  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       head_inc;
  logic [CW-1:0]       idx_plus1;
  logic [VALUE_W-1:0]  in_value;
  logic [OP_W-1:0]     in_op;

  assign head_dec  = (head_r == '0) ? LAST_A : head_r - AW'(1);
  assign head_inc  = (head_r == LAST_A) ? '0 : head_r + AW'(1);
  assign idx_plus1 = CW'(idx_r) + CW'(1);
  assign in_op     = in_tdata[OP_W-1:0];
  assign in_value  = in_tdata[OP_W+VALUE_W-1:OP_W];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = phys(head_r, idx_r);
    ram_wdata      = val_r;
    ram_raddr      = phys(head_r, idx_r);

    // result taken by the sink
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = op_t'(in_op);
          val_nxt        = in_value;
          idx_nxt        = '0;
          res_status_nxt = ST_OK;
          res_value_nxt  = '0;
          state_nxt      = S_DONE;
          unique case (op_t'(in_op))
            OP_PUSH_FRONT: begin
              if (count_r == CAP_C) begin
                res_status_nxt = ST_FULL;
              end else begin
                // new front goes just before the current head
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                ram_wdata = in_value;
                head_nxt  = head_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (count_r == CAP_C) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_r, count_r[AW-1:0]);
                ram_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_POP_FRONT, OP_DELETE, OP_SEARCH, OP_PEEK_FRONT: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // unused code: no change, ok status
            end
          endcase
        end
      end

      S_SCAN: begin
        // address for position idx_r is issued by default
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (op_r == OP_POP_FRONT || op_r == OP_PEEK_FRONT) begin
          res_value_nxt = ram_rdata;
          if (op_r == OP_POP_FRONT) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
          end
          state_nxt = S_DONE;
        end else if (ram_rdata == val_r) begin
          res_value_nxt = val_r;
          if (op_r == OP_SEARCH || idx_plus1 == count_r) begin
            // search hit, or delete of the last entry needs no close-up
            if (op_r != OP_SEARCH) begin
              count_nxt = count_r - CW'(1);
            end
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SHRD;
          end
        end else if (idx_plus1 == count_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_plus1[AW-1:0];
          state_nxt = S_SCAN;
        end
      end

      S_SHRD: begin
        // fetch the entry behind the gap
        ram_raddr = phys(head_r, idx_plus1[AW-1:0]);
        state_nxt = S_SHWR;
      end

      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, idx_r);
        ram_wdata = ram_rdata;
        idx_nxt   = idx_plus1[AW-1:0];
        if (idx_plus1 + CW'(1) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHRD;
        end
      end

      S_DONE: begin
        // load the result once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(count_r == '0), COUNT_W'(count_r), res_value_r,
                           res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_data_r   <= out_data_nxt;
  end

  ols_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

>>> src/ols_checker.sv
// port-level checker for the ordered list, bound to the top level
`default_nettype none
module ols_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  import ols_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // a failed operation returns zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[33:2] == 32'd0)
    else $error("nonzero value with failing status");

  // full status only at full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_FULL |-> out_tdata[38:34] == 5'(CAPACITY))
    else $error("full status with list not full");

  // empty flag agrees with the count while the count fits its field
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && CAPACITY < 32 |-> out_tdata[39] == (out_tdata[38:34] == 5'd0))
    else $error("empty flag disagrees with count");

endmodule

bind ordered_list_with_value_search_top ols_checker #(.CAPACITY(CAPACITY)) u_ols_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
